// ----- hdl/apq_pkg.sv -----
// Shared constants, codes and types of the array priority queue.
`default_nettype none
package apq_pkg;

    localparam int CAPACITY = 128;
    localparam int DATA_W   = 32;
    localparam int ACT_W    = 2;
    localparam int STAT_W   = 2;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH = 2'd0,
        ACT_POP  = 2'd1,
        ACT_SORT = 2'd2
    } act_e_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_e_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP_RD,
        S_LD_I,
        S_CMP,
        S_WR_I
    } state_t;

    // One write and one read address shared by the value and priority stores.
    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [IDX_W-1:0]  raddr;
        logic [DATA_W-1:0] wval;
        logic [DATA_W-1:0] wpri;
    } mem_req_t;

    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] popped;
        logic [STAT_W-1:0] status;
    } result_t;

endpackage
`default_nettype wire

// ----- hdl/apq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module apq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ----- hdl/apq_seq.sv -----
// Sequencer: counters, command decode and the shared compare-and-swap step of the sort.
`default_nettype none
module apq_seq
    import apq_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [ACT_W-1:0]  in_action,
    input  wire logic [DATA_W-1:0] in_value,
    input  wire logic [DATA_W-1:0] in_priority,
    input  wire logic              out_free,
    input  wire logic [DATA_W-1:0] rd_val,
    input  wire logic [DATA_W-1:0] rd_pri,
    output mem_req_t               mem,
    output result_t                res
);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  filled_reg, filled_next;
    logic [CNT_W-1:0]  taken_reg, taken_next;
    logic [CNT_W-1:0]  i_reg, i_next;
    logic [CNT_W-1:0]  j_reg, j_next;
    logic [DATA_W-1:0] cur_val_reg, cur_val_next;
    logic [DATA_W-1:0] cur_pri_reg, cur_pri_next;

    logic              accept;
    logic              full, empty;
    logic [CNT_W-1:0]  live, i_left, j_left;
    logic [CNT_W-1:0]  i_inc, j_inc;
    logic              i_more, j_more, swap;

    assign in_ready = (state_reg == S_IDLE) && out_free;
    assign accept   = in_valid && in_ready;
    assign full     = (filled_reg == CNT_W'(CAPACITY));
    assign empty    = (taken_reg == filled_reg);
    assign live     = filled_reg - taken_reg;
    assign i_left   = filled_reg - i_reg;
    assign j_left   = filled_reg - j_reg;
    assign i_inc    = i_reg + CNT_W'(1);
    assign j_inc    = j_reg + CNT_W'(1);
    // Another outer pass is needed while at least two entries remain from i+1 on.
    assign i_more   = i_left > CNT_W'(2);
    assign j_more   = j_left > CNT_W'(1);
    assign swap     = $signed(cur_pri_reg) <= $signed(rd_pri);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (in_action == ACT_POP && !empty) begin
                        state_next = S_POP_RD;
                    end else if (in_action == ACT_SORT && live >= CNT_W'(2)) begin
                        state_next = S_LD_I;
                    end
                end
            end
            S_POP_RD: state_next = S_IDLE;
            S_LD_I:   state_next = S_CMP;
            S_CMP: begin
                if (!j_more) begin
                    state_next = S_WR_I;
                end
            end
            S_WR_I: begin
                state_next = i_more ? S_LD_I : S_IDLE;
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb begin
        filled_next  = filled_reg;
        taken_next   = taken_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        cur_val_next = cur_val_reg;
        cur_pri_next = cur_pri_reg;
        mem          = '0;
        res          = '0;
        unique case (state_reg)
            S_IDLE: begin
                mem.raddr = taken_reg[IDX_W-1:0];
                if (accept) begin
                    res.valid  = 1'b1;
                    res.status = ST_OK;
                    unique case (in_action)
                        ACT_PUSH: begin
                            if (full) begin
                                res.status = ST_FULL;
                            end else begin
                                mem.we      = 1'b1;
                                mem.waddr   = filled_reg[IDX_W-1:0];
                                mem.wval    = in_value;
                                mem.wpri    = in_priority;
                                filled_next = filled_reg + CNT_W'(1);
                            end
                        end
                        ACT_POP: begin
                            if (empty) begin
                                res.status = ST_EMPTY;
                            end else begin
                                // The head is read now; the result is formed in S_POP_RD.
                                res.valid  = 1'b0;
                                taken_next = taken_reg + CNT_W'(1);
                            end
                        end
                        ACT_SORT: begin
                            if (live >= CNT_W'(2)) begin
                                res.valid = 1'b0;
                                i_next    = taken_reg;
                            end
                        end
                        default: begin
                            res.status = ST_OK;
                        end
                    endcase
                end
            end
            S_POP_RD: begin
                res.valid  = 1'b1;
                res.popped = rd_val;
                res.status = ST_OK;
            end
            S_LD_I: begin
                cur_val_next = rd_val;
                cur_pri_next = rd_pri;
                j_next       = i_inc;
                mem.raddr    = i_inc[IDX_W-1:0];
            end
            S_CMP: begin
                // Entry i lives in the registers; entry j swaps with it in place.
                if (swap) begin
                    mem.we       = 1'b1;
                    mem.waddr    = j_reg[IDX_W-1:0];
                    mem.wval     = cur_val_reg;
                    mem.wpri     = cur_pri_reg;
                    cur_val_next = rd_val;
                    cur_pri_next = rd_pri;
                end
                if (j_more) begin
                    j_next    = j_inc;
                    mem.raddr = j_inc[IDX_W-1:0];
                end
            end
            S_WR_I: begin
                mem.we    = 1'b1;
                mem.waddr = i_reg[IDX_W-1:0];
                mem.wval  = cur_val_reg;
                mem.wpri  = cur_pri_reg;
                mem.raddr = i_inc[IDX_W-1:0];
                i_next    = i_inc;
                if (!i_more) begin
                    res.valid  = 1'b1;
                    res.status = ST_OK;
                end
            end
            default: begin
                res = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            filled_reg <= '0;
            taken_reg  <= '0;
            i_reg      <= '0;
            j_reg      <= '0;
        end else begin
            state_reg  <= state_next;
            filled_reg <= filled_next;
            taken_reg  <= taken_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
        end
        cur_val_reg <= cur_val_next;
        cur_pri_reg <= cur_pri_next;
    end

    a_taken_le_filled: assert property (@(posedge aclk) disable iff (!aresetn)
        taken_reg <= filled_reg)
        else $error("taken count passed filled count");

    a_filled_le_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        filled_reg <= CNT_W'(CAPACITY))
        else $error("filled count passed capacity");

    a_pop_result: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_POP_RD |-> res.valid && out_free)
        else $error("pop result without a free output slot");

    a_sort_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CMP) |-> (j_reg > i_reg) && (j_reg < filled_reg)
                                 && (i_reg >= taken_reg))
        else $error("sort index outside the live entries");

    a_idle_after_result: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid |=> state_reg == S_IDLE)
        else $error("sequencer busy after its result");

endmodule
`default_nettype wire

// ----- hdl/array_priority_queue_sort_top.sv -----
// Push, unused action, empty pop and a sort of fewer than two live entries give
// their result beat from the idle state; a good pop reads the head, then S_POP_RD.
// A sort runs S_LD_I, S_CMP over each later entry and S_WR_I for every outer pass,
// the single compare-and-swap step reading one store entry per cycle.
// One item at a time; the next beat is taken once the result register is free.
// Reset (aresetn low, synchronous) empties the queue; the stores are not cleared.
`default_nettype none
module array_priority_queue_sort_top
    import apq_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [2*DATA_W-1:0]   s_tdata,  // value [31:0], priority_req [63:32]
    input  wire logic [ACT_W-1:0]      s_tuser,  // action [1:0]
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [DATA_W-1:0]     m_tdata,  // popped_value [31:0]
    output logic      [STAT_W-1:0]     m_tuser   // status [1:0]
);

    mem_req_t          mem;
    result_t           res;
    logic [DATA_W-1:0] rd_val, rd_pri;
    logic              out_free;

    logic              m_valid_reg;
    logic [DATA_W-1:0] m_data_reg;
    logic [STAT_W-1:0] m_user_reg;

    assign out_free = !m_valid_reg || m_tready;

    apq_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_action   (s_tuser),
        .in_value    (s_tdata[DATA_W-1:0]),
        .in_priority (s_tdata[2*DATA_W-1:DATA_W]),
        .out_free    (out_free),
        .rd_val      (rd_val),
        .rd_pri      (rd_pri),
        .mem         (mem),
        .res         (res)
    );

    apq_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_val_ram (
        .aclk  (aclk),
        .we    (mem.we),
        .waddr (mem.waddr),
        .wdata (mem.wval),
        .raddr (mem.raddr),
        .rdata (rd_val)
    );

    apq_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_pri_ram (
        .aclk  (aclk),
        .we    (mem.we),
        .waddr (mem.waddr),
        .wdata (mem.wpri),
        .raddr (mem.raddr),
        .rdata (rd_pri)
    );

    // Result register: holds one beat until the sink takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res.valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (res.valid) begin
            m_data_reg <= res.popped;
            m_user_reg <= res.status;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule
`default_nettype wire

// ----- verif/array_priority_queue_sort_top_tb.sv -----
// Self-checking stream testbench of the array priority queue with its own queue predictor.
`timescale 1ns / 100ps
`default_nettype none
module array_priority_queue_sort_top_tb;
    import apq_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_ITEMS = 750;
    localparam int END_WAIT = 50;
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    typedef struct {
        logic [ACT_W-1:0]  act;
        logic [DATA_W-1:0] value;
        logic [DATA_W-1:0] prio;
        bit                drain_first;
    } queue_cmd_t;

    typedef struct {
        logic [DATA_W-1:0] popped;
        logic [STAT_W-1:0] status;
    } pop_result_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [2*DATA_W-1:0] s_tdata = '0;
    logic [ACT_W-1:0]    s_tuser = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [DATA_W-1:0]   m_tdata;
    logic [STAT_W-1:0]   m_tuser;

    array_priority_queue_sort_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    queue_cmd_t  pending_cmds[$];
    pop_result_t expected_results[$];
    queue_cmd_t  beat_in_flight;
    pop_result_t want;
    bit          accepted_now;

    int n_sent = 0;
    int n_checked = 0;
    int err_cnt = 0;
    int cycle_cnt = 0;
    int hold_cnt = 0;
    bit [1:0] hold_done = '0;
    int tx_idle_pct;
    int rx_idle_pct;

    // Predictor copy of the queue.
    logic signed [DATA_W-1:0] q_val [CAPACITY];
    logic signed [DATA_W-1:0] q_pri [CAPACITY];
    int q_filled = 0;
    int q_taken = 0;

    int cnt_stored = 0, cnt_full = 0, cnt_popped = 0, cnt_empty = 0;
    int cnt_sort = 0, cnt_unused = 0, widest_sort = 0;

    assign tx_idle_pct = (n_sent < 250) ? 24 : (n_sent < 500) ? 66 : 0;
    assign rx_idle_pct = (n_sent < 250) ? 66 : (n_sent < 500) ? 24 : 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    task automatic note_mismatch(input string what, input logic [DATA_W-1:0] exp_v,
                                 input logic [DATA_W-1:0] act_v);
        err_cnt++;
        if (err_cnt <= 10)
            $display("mismatch at beat %0d: %s expected %h got %h", n_checked, what, exp_v, act_v);
    endtask

    task automatic predict_queue_result(input queue_cmd_t cmd);
        pop_result_t r;
        logic signed [DATA_W-1:0] t;
        int i, j;
        r.popped = '0;
        r.status = ST_OK;
        case (cmd.act)
            ACT_PUSH: begin
                if (q_filled >= CAPACITY) begin
                    r.status = ST_FULL;
                    cnt_full++;
                end else begin
                    q_val[q_filled] = cmd.value;
                    q_pri[q_filled] = cmd.prio;
                    q_filled++;
                    cnt_stored++;
                end
            end
            ACT_POP: begin
                if (q_taken >= q_filled) begin
                    r.status = ST_EMPTY;
                    cnt_empty++;
                end else begin
                    r.popped = q_val[q_taken];
                    q_taken++;
                    cnt_popped++;
                end
            end
            ACT_SORT: begin
                cnt_sort++;
                if (q_filled - q_taken > widest_sort)
                    widest_sort = q_filled - q_taken;
                // Exchange sort over the live slots; ties swap as well.
                for (i = q_taken; i + 1 < q_filled; i++) begin
                    for (j = i + 1; j < q_filled; j++) begin
                        if (q_pri[i] <= q_pri[j]) begin
                            t = q_pri[i]; q_pri[i] = q_pri[j]; q_pri[j] = t;
                            t = q_val[i]; q_val[i] = q_val[j]; q_val[j] = t;
                        end
                    end
                end
            end
            default: begin
                cnt_unused++;
            end
        endcase
        expected_results.push_back(r);
    endtask

    task automatic add_cmd(input logic [ACT_W-1:0] act, input logic [DATA_W-1:0] v,
                           input logic [DATA_W-1:0] p, input bit drain);
        queue_cmd_t c;
        c.act = act;
        c.value = v;
        c.prio = p;
        c.drain_first = drain;
        pending_cmds.push_back(c);
    endtask

    // Plain random words mixed with the extremes and a narrow band that makes ties likely.
    function automatic logic [DATA_W-1:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            4: return $urandom_range(0, 7) - 4;
            default: return $urandom;
        endcase
    endfunction

    // Driver: offers the pending commands, predicting each one when its beat is taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            accepted_now = s_tvalid && s_tready;
            if (accepted_now) begin
                predict_queue_result(beat_in_flight);
                n_sent <= n_sent + 1;
            end
            if (!s_tvalid || accepted_now) begin
                if (pending_cmds.size() == 0 || $urandom_range(0, 99) < tx_idle_pct) begin
                    s_tvalid <= 1'b0;
                end else if (pending_cmds[0].drain_first &&
                             (accepted_now || n_sent != n_checked)) begin
                    s_tvalid <= 1'b0;
                end else begin
                    beat_in_flight = pending_cmds.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {beat_in_flight.prio, beat_in_flight.value};
                    s_tuser <= beat_in_flight.act;
                end
            end
        end
    end

    // Long receiver hold-offs so that the block backs up into its input.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_cnt <= 0;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end else if (!hold_done[0] && n_sent >= 40) begin
            hold_cnt <= HOLD_CYCLES;
            hold_done[0] <= 1'b1;
        end else if (!hold_done[1] && n_sent >= 400) begin
            hold_cnt <= HOLD_CYCLES;
            hold_done[1] <= 1'b1;
        end
    end

    // Monitor: checks every result beat against the oldest prediction.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    note_mismatch("unexpected beat, data", '0, m_tdata);
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata !== want.popped)
                        note_mismatch("popped_value", want.popped, m_tdata);
                    if (m_tuser !== want.status)
                        note_mismatch("status", DATA_W'(want.status), DATA_W'(m_tuser));
                end
                n_checked <= n_checked + 1;
            end
            m_tready <= (hold_cnt == 0) && ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats still expected",
                     cycle_cnt, expected_results.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        int n_random;
        int n, k;
        bit drain;
        // Directed: empty queue, unused code, extremes, ties and pop order.
        add_cmd(ACT_POP, 32'h1234_5678, 32'h0, 1'b0);
        add_cmd(ACT_SORT, 32'h0, 32'h0, 1'b0);
        add_cmd(ACT_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        add_cmd(ACT_PUSH, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        add_cmd(ACT_SORT, 32'h0, 32'h0, 1'b0);
        add_cmd(ACT_PUSH, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        add_cmd(ACT_PUSH, 32'h0000_0000, 32'h0000_0000, 1'b0);
        add_cmd(ACT_PUSH, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
        add_cmd(ACT_PUSH, 32'h5555_5555, 32'hFFFF_FFFF, 1'b0);
        add_cmd(ACT_PUSH, 32'hAAAA_AAAA, 32'h7FFF_FFFF, 1'b0);
        add_cmd(ACT_SORT, 32'h0, 32'h0, 1'b1);
        repeat (5) add_cmd(ACT_POP, 32'h0, 32'h0, 1'b0);
        add_cmd(ACT_POP, 32'h0, 32'h0, 1'b0);
        add_cmd(ACT_UNUSED, 32'h0, 32'h0, 1'b0);
        add_cmd(ACT_PUSH, 32'h1, 32'h1, 1'b0);
        add_cmd(ACT_PUSH, 32'h2, 32'h1, 1'b0);
        add_cmd(ACT_SORT, 32'h0, 32'h0, 1'b0);
        add_cmd(ACT_POP, 32'h0, 32'h0, 1'b0);

        // Random: push bursts, mostly followed by a sort, then pops; now and then a long burst,
        // the rest single noise commands. The slots run out partway through.
        n_random = 0;
        while (n_random < RANDOM_ITEMS) begin
            k = $urandom_range(0, 19);
            if (k < 13 || k == 19) begin
                n = (k == 19) ? $urandom_range(8, 24) : $urandom_range(1, 3);
                drain = ($urandom_range(0, 7) == 0);
                for (int i = 0; i < n; i++) begin
                    add_cmd(ACT_PUSH, rand_word(), rand_word(), drain && i == 0);
                end
                if ($urandom_range(0, 4) != 0) begin
                    add_cmd(ACT_SORT, $urandom, $urandom, 1'b0);
                    n_random++;
                end
                n_random += n;
                n = n - 1 + $urandom_range(0, 2);
                for (int i = 0; i < n; i++) begin
                    add_cmd(ACT_POP, $urandom, $urandom, 1'b0);
                end
                n_random += n;
            end else begin
                add_cmd(ACT_W'($urandom_range(0, 3)), rand_word(), rand_word(), 1'b0);
                n_random++;
            end
        end

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_cmds.size() != 0 || s_tvalid || n_checked != n_sent)
            @(posedge aclk);
        repeat (END_WAIT) @(posedge aclk);

        while (expected_results.size() != 0) begin
            want = expected_results.pop_front();
            note_mismatch("missing beat, popped_value", want.popped, 'x);
        end

        $display("Ran %0d commands: %0d pushes stored, %0d dropped as full, %0d pops, %0d empty pops,",
                 n_sent, cnt_stored, cnt_full, cnt_popped, cnt_empty);
        $display("%0d sorts (widest %0d live entries), %0d unused codes; %0d mismatches.",
                 cnt_sort, widest_sort, cnt_unused, err_cnt);
        if (err_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire
